[hdl/hsvs_pkg.sv]
`default_nettype none

package hsvs_pkg;

  localparam int unsigned HueSteps  = 43;
  localparam int unsigned FracScale = 6;
  localparam logic [7:0]  FullLevel = 8'hFF;
  localparam int unsigned FixShift  = 8;

  typedef enum logic [2:0] {
    RGN_RED_YEL  = 3'd0,
    RGN_YEL_GRN  = 3'd1,
    RGN_GRN_CYN  = 3'd2,
    RGN_CYN_BLU  = 3'd3,
    RGN_BLU_MAG  = 3'd4,
    RGN_MAG_RED  = 3'd5
  } region_e;

  // first-stage word: hue split into region and fraction
  typedef struct packed {
    logic       valid;
    logic       grey;
    region_e    region;
    logic [7:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] bright;
  } split_t;

  // level word: p, q, t ready for channel selection
  typedef struct packed {
    logic       valid;
    logic       grey;
    region_e    region;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
    logic [7:0] bright;
  } level_t;

  function automatic logic [7:0] region_base(region_e r);
    logic [7:0] b;
    unique case (r)
      RGN_RED_YEL: b = 8'(0 * HueSteps);
      RGN_YEL_GRN: b = 8'(1 * HueSteps);
      RGN_GRN_CYN: b = 8'(2 * HueSteps);
      RGN_CYN_BLU: b = 8'(3 * HueSteps);
      RGN_BLU_MAG: b = 8'(4 * HueSteps);
      RGN_MAG_RED: b = 8'(5 * HueSteps);
      default:     b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hdl/hsv_to_rgb_scaled_top.sv]
// An accepted word passes the u_region, u_levels (a, then b) and u_scale registers, in that order, to valid_o.
// Throughput: one word per cycle while busy is low; busy is registered and falls once reset is released.
// Stages: region split, p/q/t factors, p/q/t products, channel select with brightness.
// Results are presented for one cycle and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) clears all valid bits; busy is high while in reset.
`default_nettype none

module hsv_to_rgb_scaled_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] hue_i,
  input  wire logic [7:0] saturation_i,
  input  wire logic [7:0] value_i,
  input  wire logic [7:0] brightness_i,
  output logic            valid_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o
);

  logic             busy_q;
  logic             accept;
  hsvs_pkg::split_t split;
  hsvs_pkg::level_t level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  hsvs_region u_region (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .value_i      (value_i),
    .brightness_i (brightness_i),
    .split_o      (split)
  );

  hsvs_levels u_levels (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .split_i (split),
    .level_o (level)
  );

  hsvs_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .level_i (level),
    .valid_o (valid_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 valid_o)
    else $error("accepted word did not emerge after 4 cycles");

  a_grey_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level.valid && level.grey) |=> (red_o == green_o && green_o == blue_o))
    else $error("grey word produced unequal channels");

  a_valid_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    split.valid |=> ##1 level.valid)
    else $error("valid bit lost inside the pipeline");

endmodule

`default_nettype wire

[hdl/hsvs_region.sv]
`default_nettype none

module hsvs_region (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [7:0]      hue_i,
  input  wire logic [7:0]      saturation_i,
  input  wire logic [7:0]      value_i,
  input  wire logic [7:0]      brightness_i,
  output hsvs_pkg::split_t     split_o
);

  hsvs_pkg::region_e region;
  logic [7:0]        offset_full;
  logic [5:0]        offset;
  logic [7:0]        frac;
  logic              valid_q;
  hsvs_pkg::split_t  data_q;

  always_comb begin
    priority if (hue_i >= 8'(5 * hsvs_pkg::HueSteps)) begin
      region = hsvs_pkg::RGN_MAG_RED;
    end else if (hue_i >= 8'(4 * hsvs_pkg::HueSteps)) begin
      region = hsvs_pkg::RGN_BLU_MAG;
    end else if (hue_i >= 8'(3 * hsvs_pkg::HueSteps)) begin
      region = hsvs_pkg::RGN_CYN_BLU;
    end else if (hue_i >= 8'(2 * hsvs_pkg::HueSteps)) begin
      region = hsvs_pkg::RGN_GRN_CYN;
    end else if (hue_i >= 8'(1 * hsvs_pkg::HueSteps)) begin
      region = hsvs_pkg::RGN_YEL_GRN;
    end else begin
      region = hsvs_pkg::RGN_RED_YEL;
    end
  end

  assign offset_full = hue_i - hsvs_pkg::region_base(region);
  assign offset      = offset_full[5:0];
  // offset * 6 as 4x + 2x, at most 252
  assign frac        = {offset, 2'b00} + {1'b0, offset, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q.valid  <= 1'b0;
    data_q.grey   <= (saturation_i == 8'd0);
    data_q.region <= region;
    data_q.frac   <= frac;
    data_q.sat    <= saturation_i;
    data_q.val    <= value_i;
    data_q.bright <= brightness_i;
  end

  always_comb begin
    split_o       = data_q;
    split_o.valid = valid_q;
  end

endmodule

`default_nettype wire

[hdl/hsvs_levels.sv]
`default_nettype none

module hsvs_levels (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  hsvs_pkg::split_t     split_i,
  output hsvs_pkg::level_t     level_o
);

  logic [15:0] sf_prod;
  logic [15:0] st_prod;

  logic              valid_a_q;
  logic              grey_a_q;
  hsvs_pkg::region_e region_a_q;
  logic [7:0]        val_a_q;
  logic [7:0]        bright_a_q;
  logic [7:0]        inv_p_a_q;
  logic [7:0]        inv_q_a_q;
  logic [7:0]        inv_t_a_q;

  logic [15:0] p_prod;
  logic [15:0] q_prod;
  logic [15:0] t_prod;

  logic             valid_b_q;
  hsvs_pkg::level_t data_b_q;

  assign sf_prod = 16'(split_i.sat) * 16'(split_i.frac);
  assign st_prod = 16'(split_i.sat) * 16'(hsvs_pkg::FullLevel - split_i.frac);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= split_i.valid;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    grey_a_q   <= split_i.grey;
    region_a_q <= split_i.region;
    val_a_q    <= split_i.val;
    bright_a_q <= split_i.bright;
    inv_p_a_q  <= hsvs_pkg::FullLevel - split_i.sat;
    inv_q_a_q  <= hsvs_pkg::FullLevel - sf_prod[15:hsvs_pkg::FixShift];
    inv_t_a_q  <= hsvs_pkg::FullLevel - st_prod[15:hsvs_pkg::FixShift];
  end

  assign p_prod = 16'(val_a_q) * 16'(inv_p_a_q);
  assign q_prod = 16'(val_a_q) * 16'(inv_q_a_q);
  assign t_prod = 16'(val_a_q) * 16'(inv_t_a_q);

  always_ff @(posedge clk_i) begin
    data_b_q.valid  <= 1'b0;
    data_b_q.grey   <= grey_a_q;
    data_b_q.region <= region_a_q;
    data_b_q.val    <= val_a_q;
    data_b_q.p      <= p_prod[15:hsvs_pkg::FixShift];
    data_b_q.q      <= q_prod[15:hsvs_pkg::FixShift];
    data_b_q.t      <= t_prod[15:hsvs_pkg::FixShift];
    data_b_q.bright <= bright_a_q;
  end

  always_comb begin
    level_o       = data_b_q;
    level_o.valid = valid_b_q;
  end

endmodule

`default_nettype wire

[hdl/hsvs_scale.sv]
`default_nettype none

module hsvs_scale (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  hsvs_pkg::level_t     level_i,
  output logic                 valid_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o
);

  logic [7:0]  r_ch;
  logic [7:0]  g_ch;
  logic [7:0]  b_ch;
  logic [8:0]  gain;
  logic [16:0] r_prod;
  logic [16:0] g_prod;
  logic [16:0] b_prod;

  logic       valid_q;
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;

  always_comb begin
    if (level_i.grey) begin
      r_ch = level_i.val;
      g_ch = level_i.val;
      b_ch = level_i.val;
    end else begin
      unique case (level_i.region)
        hsvs_pkg::RGN_RED_YEL: begin
          r_ch = level_i.val; g_ch = level_i.t;   b_ch = level_i.p;
        end
        hsvs_pkg::RGN_YEL_GRN: begin
          r_ch = level_i.q;   g_ch = level_i.val; b_ch = level_i.p;
        end
        hsvs_pkg::RGN_GRN_CYN: begin
          r_ch = level_i.p;   g_ch = level_i.val; b_ch = level_i.t;
        end
        hsvs_pkg::RGN_CYN_BLU: begin
          r_ch = level_i.p;   g_ch = level_i.q;   b_ch = level_i.val;
        end
        hsvs_pkg::RGN_BLU_MAG: begin
          r_ch = level_i.t;   g_ch = level_i.p;   b_ch = level_i.val;
        end
        default: begin
          r_ch = level_i.val; g_ch = level_i.p;   b_ch = level_i.q;
        end
      endcase
    end
  end

  assign gain   = {1'b0, level_i.bright} + 9'd1;
  assign r_prod = 17'(gain) * 17'(r_ch);
  assign g_prod = 17'(gain) * 17'(g_ch);
  assign b_prod = 17'(gain) * 17'(b_ch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= level_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= r_prod[15:hsvs_pkg::FixShift];
    green_q <= g_prod[15:hsvs_pkg::FixShift];
    blue_q  <= b_prod[15:hsvs_pkg::FixShift];
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire
